### rtl/core/rsd_pkg.sv
package rsd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_POINTS_DEF   = 769;
  localparam int HEADER_BYTES_DEF = 12;
  localparam int LINE_CHARS_DEF   = 64;

  // Fixed field widths
  localparam int CNT_W    = 10;
  localparam int DIST_W   = 12;
  localparam int SIX_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int CHARS_W  = CNT_W + 1;

  // Header position that carries the status character
  localparam int STATUS_POS = 10;
  // Character bias, reduced to the six bits that survive the mask
  localparam logic [SIX_W-1:0] CHAR_BIAS = 6'h30;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;

  // Reciprocal used to split the character count into whole lines
  localparam int RECIP_SHIFT = CHARS_W;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIST_W-1:0] dist_t;

endpackage

### rtl/core/rsd_ifs.sv
interface rsd_in_if;
  logic               valid;
  logic               ready;
  rsd_pkg::byte_t     rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rsd_out_if;
  logic               valid;
  logic               ready;
  rsd_pkg::dist_t     distance_value;
  rsd_pkg::cnt_t      point_index;
  rsd_pkg::byte_t     status_byte;
  logic               last_point;

  modport source (output valid, output distance_value, output point_index,
                  output status_byte, output last_point, input ready);
  modport sink   (input valid, input distance_value, input point_index,
                  input status_byte, input last_point, output ready);
endinterface

### rtl/core/rsd_cfg.sv
module rsd_cfg #(
  parameter int MAX_POINTS   = rsd_pkg::MAX_POINTS_DEF,
  parameter int HEADER_BYTES = rsd_pkg::HEADER_BYTES_DEF,
  parameter int LINE_CHARS   = rsd_pkg::LINE_CHARS_DEF,
  parameter int FRAME_W      = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rsd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rsd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rsd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output rsd_pkg::cnt_t                   n_eff,
  output logic [FRAME_W-1:0]              frame_len
);
  import rsd_pkg::*;

  localparam int NMAX      = (MAX_POINTS > 1023) ? 1023 : MAX_POINTS;
  localparam int RECIP     = (1 << RECIP_SHIFT) / LINE_CHARS;
  localparam int PROD_W    = 2 * CHARS_W;
  localparam int LEN_RST   = HEADER_BYTES + 2 + 2 + 2 / LINE_CHARS;

  cnt_t                  pc_r;
  cnt_t                  n_eff_r, n_eff_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [FRAME_W-1:0]    len_r, len_nxt;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;
  logic [CHARS_W-1:0]    chars_w, chars_r;
  logic [CHARS_W-1:0]    q0, q;
  logic [PROD_W-1:0]     q0_l;
  logic [CHARS_W:0]      rem;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_POINT_COUNT);
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_POINT_COUNT: prdata = APB_DATA_W'(pc_r);
      default:         prdata = '0;
    endcase
  end

  // Clamp the written count and start the line split from it
  always_comb begin
    cnt_t wv;
    wv = pwdata[CNT_W-1:0];
    if (wv == '0) begin
      n_eff_nxt = CNT_W'(1);
    end else if (wv > CNT_W'(NMAX)) begin
      n_eff_nxt = CNT_W'(NMAX);
    end else begin
      n_eff_nxt = wv;
    end
    chars_w  = {n_eff_nxt, 1'b0};
    prod_nxt = PROD_W'(chars_w) * PROD_W'(RECIP);
  end

  // Quotient estimate is exact or one short; fix it with one compare
  always_comb begin
    chars_r = {n_eff_r, 1'b0};
    q0      = prod_r[PROD_W-1 -: CHARS_W];
    q0_l    = PROD_W'(q0) * PROD_W'(LINE_CHARS);
    rem     = (CHARS_W+1)'(chars_r) - q0_l[CHARS_W:0];
    q       = (rem >= (CHARS_W+1)'(LINE_CHARS)) ? q0 + CHARS_W'(1) : q0;
    len_nxt = FRAME_W'(HEADER_BYTES + 2) + FRAME_W'(chars_r) + FRAME_W'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= CNT_W'(1);
      n_eff_r <= CNT_W'(1);
      prod_r  <= PROD_W'(2 * RECIP);
      len_r   <= FRAME_W'(LEN_RST);
    end else begin
      if (wr_en) begin
        pc_r    <= pwdata[CNT_W-1:0];
        n_eff_r <= n_eff_nxt;
        prod_r  <= prod_nxt;
      end
      len_r <= len_nxt;
    end
  end

  assign n_eff     = n_eff_r;
  assign frame_len = len_r;

  a_neff_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_eff_r != '0) && (n_eff_r <= CNT_W'(NMAX)))
    else $error("effective point count out of range");

  a_len_settles: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en && $past(!wr_en) |-> len_r == len_nxt)
    else $error("frame length did not settle after a write");

  a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
    len_r >= FRAME_W'(HEADER_BYTES + 4))
    else $error("frame length below header plus one point");

endmodule

### rtl/core/rsd_core.sv
module rsd_core #(
  parameter int HEADER_BYTES = rsd_pkg::HEADER_BYTES_DEF,
  parameter int LINE_CHARS   = rsd_pkg::LINE_CHARS_DEF,
  parameter int FRAME_W      = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  rsd_in_if.sink              in_ch,
  rsd_out_if.source           out_ch,
  input  rsd_pkg::cnt_t       n_eff,
  input  logic [FRAME_W-1:0]  frame_len
);
  import rsd_pkg::*;

  localparam int LC_W = $clog2(LINE_CHARS + 1);

  // Input register
  logic                  in_vld_r;
  byte_t                 in_byte_r;

  // Frame state
  logic [FRAME_W-1:0]    pos_r, pos_nxt;
  logic [LC_W-1:0]       lcc_r, lcc_nxt;
  cnt_t                  pe_r, pe_nxt;
  logic [SIX_W-1:0]      hi_r, hi_nxt;
  logic                  second_r, second_nxt;
  byte_t                 status_r, status_nxt;

  // Result register
  logic                  out_vld_r;
  dist_t                 dist_r;
  cnt_t                  idx_r;
  byte_t                 stat_out_r;
  logic                  last_r;

  logic                  step_go;
  logic                  produce;
  logic [SIX_W-1:0]      six;
  logic [FRAME_W-1:0]    pos_inc;

  assign step_go      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step_go;

  always_comb begin
    pos_nxt    = pos_r;
    lcc_nxt    = lcc_r;
    pe_nxt     = pe_r;
    hi_nxt     = hi_r;
    second_nxt = second_r;
    status_nxt = status_r;
    produce    = 1'b0;
    six        = in_byte_r[SIX_W-1:0] - CHAR_BIAS;
    pos_inc    = pos_r + FRAME_W'(1);

    if (pos_r < FRAME_W'(HEADER_BYTES)) begin
      if (pos_r == FRAME_W'(STATUS_POS)) begin
        status_nxt = in_byte_r;
      end
    end else if (lcc_r >= LC_W'(LINE_CHARS)) begin
      // drop the line feed that closes a full line
      lcc_nxt = '0;
    end else if (pe_r < n_eff) begin
      lcc_nxt = lcc_r + LC_W'(1);
      if (!second_r) begin
        hi_nxt     = six;
        second_nxt = 1'b1;
      end else begin
        produce    = 1'b1;
        pe_nxt     = pe_r + CNT_W'(1);
        second_nxt = 1'b0;
      end
    end

    pos_nxt = pos_inc;
    if (pos_inc >= frame_len) begin
      pos_nxt    = '0;
      lcc_nxt    = '0;
      pe_nxt     = '0;
      second_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= '0;
      lcc_r     <= '0;
      pe_r      <= '0;
      hi_r      <= '0;
      second_r  <= 1'b0;
      status_r  <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (step_go) begin
        pos_r    <= pos_nxt;
        lcc_r    <= lcc_nxt;
        pe_r     <= pe_nxt;
        hi_r     <= hi_nxt;
        second_r <= second_nxt;
        status_r <= status_nxt;
      end
      if (step_go && produce) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (step_go && produce) begin
      dist_r     <= {hi_r, six};
      idx_r      <= pe_r;
      stat_out_r <= status_r;
      last_r     <= ((pe_r + CNT_W'(1)) == n_eff);
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.distance_value = dist_r;
  assign out_ch.point_index    = idx_r;
  assign out_ch.status_byte    = stat_out_r;
  assign out_ch.last_point     = last_r;

  a_lcc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lcc_r <= LC_W'(LINE_CHARS))
    else $error("line character count beyond a full line");

  a_frame_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == '0 |-> (lcc_r == '0) && (pe_r == '0) && !second_r)
    else $error("frame start with stale data state");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    step_go && produce |=> out_vld_r)
    else $error("completed distance not presented");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

### rtl/core/range_scan_reply_decoder_top.sv
// Range scan reply decoder. Takes the reply one byte per transaction on
// in_ch and presents each 12-bit distance on out_ch with its point index,
// the frame status (header position ten) and a last-point mark. One byte
// is taken every cycle while the result is not stalled; a distance is
// presented once its second character has passed from the input register
// into the result register, and a stalled result holds only the byte behind
// it. The frame length follows point_count (APB register at address 0): the
// line split of the character count goes through a reciprocal multiply
// registered in two steps, prod_r and then len_r, while n_eff takes a write
// directly. prdata returns the low ten bits of the value written, unclamped.
module range_scan_reply_decoder_top #(
  parameter int MAX_POINTS   = rsd_pkg::MAX_POINTS_DEF,
  parameter int HEADER_BYTES = rsd_pkg::HEADER_BYTES_DEF,
  parameter int LINE_CHARS   = rsd_pkg::LINE_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rsd_in_if.sink                          in_ch,
  rsd_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rsd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rsd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rsd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rsd_pkg::*;

  localparam int NMAX      = (MAX_POINTS > 1023) ? 1023 : MAX_POINTS;
  localparam int CMAX      = 2 * NMAX;
  localparam int FLEN_MAX  = HEADER_BYTES + 2 + CMAX + CMAX / LINE_CHARS;
  localparam int FLEN_W    = $clog2(FLEN_MAX + 1);
  localparam int FRAME_W   = (FLEN_W < 4) ? 4 : FLEN_W;

  cnt_t                n_eff;
  logic [FRAME_W-1:0]  frame_len;

  rsd_cfg #(
    .MAX_POINTS   (MAX_POINTS),
    .HEADER_BYTES (HEADER_BYTES),
    .LINE_CHARS   (LINE_CHARS),
    .FRAME_W      (FRAME_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .n_eff     (n_eff),
    .frame_len (frame_len)
  );

  rsd_core #(
    .HEADER_BYTES (HEADER_BYTES),
    .LINE_CHARS   (LINE_CHARS),
    .FRAME_W      (FRAME_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .n_eff     (n_eff),
    .frame_len (frame_len)
  );

endmodule
